/* rtl/i2p_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_pkg: shared types and constants of the infix-to-postfix converter
// Operator codes, character classes, result beat layout, sequencer states.
// ----------------------------------------------------------------------------
package i2p_pkg;

	// ASCII codes of the special characters
	localparam logic [7:0] CH_LPAR = 8'h28;
	localparam logic [7:0] CH_RPAR = 8'h29;
	localparam logic [7:0] CH_MUL  = 8'h2A;
	localparam logic [7:0] CH_ADD  = 8'h2B;
	localparam logic [7:0] CH_SUB  = 8'h2D;
	localparam logic [7:0] CH_DIV  = 8'h2F;

	// stack entry codes
	typedef enum logic [2:0] {
		OP_LPAR = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4
	} op_code_t;

	typedef enum logic [1:0] {
		KIND_OPERAND,
		KIND_LPAR,
		KIND_RPAR,
		KIND_OPER
	} sym_kind_t;

	// what the pop loop is doing
	typedef enum logic [1:0] {
		MODE_CLOSE,
		MODE_OPER,
		MODE_FLUSH
	} pop_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_READ,
		ST_EVAL,
		ST_PUSH,
		ST_FAULT,
		ST_FINISH
	} seq_state_t;

	// one result beat, without the last flag
	typedef struct packed {
		logic [7:0] sym;
		logic       has;
		logic       fault;
	} out_beat_t;

	// sequencer to output buffer
	typedef struct packed {
		logic      emit;
		logic      drain;
		logic      drain_last;
		out_beat_t beat;
	} emit_req_t;

	function automatic sym_kind_t sym_kind(input logic [7:0] s);
		sym_kind_t k;
		case (s)
			CH_LPAR: k = KIND_LPAR;
			CH_RPAR: k = KIND_RPAR;
			CH_ADD, CH_SUB, CH_MUL, CH_DIV: k = KIND_OPER;
			default: k = KIND_OPERAND;
		endcase
		return k;
	endfunction

	function automatic op_code_t sym_code(input logic [7:0] s);
		op_code_t c;
		case (s)
			CH_ADD:  c = OP_ADD;
			CH_SUB:  c = OP_SUB;
			CH_MUL:  c = OP_MUL;
			CH_DIV:  c = OP_DIV;
			default: c = OP_LPAR;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] code_char(input op_code_t c);
		logic [7:0] ch;
		case (c)
			OP_LPAR: ch = CH_LPAR;
			OP_ADD:  ch = CH_ADD;
			OP_SUB:  ch = CH_SUB;
			OP_MUL:  ch = CH_MUL;
			OP_DIV:  ch = CH_DIV;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [1:0] code_prio(input op_code_t c);
		logic [1:0] p;
		case (c)
			OP_ADD, OP_SUB: p = 2'd1;
			OP_MUL, OP_DIV: p = 2'd2;
			default:        p = 2'd0;
		endcase
		return p;
	endfunction

endpackage

/* rtl/i2p_stack.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_stack: operator stack storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module i2p_stack #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [2:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [2:0]    rdata
);
	import i2p_pkg::*;

	logic [2:0] mem [DEPTH];
	logic [2:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/i2p_outbuf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_outbuf: result holding stage and output register
// Keeps the newest beat back so the end flag can be set on it later.
// ----------------------------------------------------------------------------
module i2p_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  i2p_pkg::emit_req_t req,
	output logic              ok,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // [7:0] out_symbol
	output logic [1:0]        m_tuser,   // [0] has_symbol, [1] fault
	output logic              m_tlast    // last_out
);
	import i2p_pkg::*;

	logic      pend_v_q;
	out_beat_t pend_q;
	logic      ob_v_q;
	out_beat_t ob_q;
	logic      ob_last_q;

	logic      ob_free;
	logic      ob_load;
	out_beat_t ob_d;
	logic      ob_last_d;
	logic      pend_load;
	logic      pend_clr;

	assign ob_free = !ob_v_q || m_tready;

	// handshake with the sequencer
	always_comb begin
		ok        = 1'b0;
		ob_load   = 1'b0;
		ob_d      = pend_q;
		ob_last_d = 1'b0;
		pend_load = 1'b0;
		pend_clr  = 1'b0;
		if (req.emit) begin
			ok = !pend_v_q || ob_free;
			if (ok) begin
				pend_load = 1'b1;
				ob_load   = pend_v_q;
			end
		end else if (req.drain) begin
			if (pend_v_q) begin
				ok        = ob_free;
				ob_load   = ob_free;
				ob_last_d = req.drain_last;
				pend_clr  = ob_free;
			end else if (req.drain_last) begin
				// bare end marker
				ok        = ob_free;
				ob_load   = ob_free;
				ob_d      = '{sym: 8'h00, has: 1'b0, fault: 1'b0};
				ob_last_d = 1'b1;
			end else begin
				ok = 1'b1;
			end
		end
	end

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			ob_v_q   <= 1'b0;
		end else begin
			if (pend_load) begin
				pend_v_q <= 1'b1;
			end else if (pend_clr) begin
				pend_v_q <= 1'b0;
			end
			if (ob_load) begin
				ob_v_q <= 1'b1;
			end else if (m_tready) begin
				ob_v_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (pend_load) begin
			pend_q <= req.beat;
		end
		if (ob_load) begin
			ob_q      <= ob_d;
			ob_last_q <= ob_last_d;
		end
	end

	assign m_tvalid = ob_v_q;
	assign m_tdata  = ob_q.sym;
	assign m_tuser  = {ob_q.fault, ob_q.has};
	assign m_tlast  = ob_last_q;

endmodule

/* rtl/i2p_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_seq: shunting-yard sequencer
// Pops the stack one entry per read/compare step and issues result beats.
// ----------------------------------------------------------------------------
module i2p_seq #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int CW    = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,
	input  logic               s_tlast,
	output logic               st_we,
	output logic [AW-1:0]      st_waddr,
	output logic [2:0]         st_wdata,
	output logic               st_re,
	output logic [AW-1:0]      st_raddr,
	input  logic [2:0]         st_rdata,
	output i2p_pkg::emit_req_t req,
	input  logic               ok
);
	import i2p_pkg::*;

	seq_state_t state_q, state_d;
	pop_mode_t  mode_q, mode_d;
	logic [CW-1:0] count_q, count_d;
	logic [7:0]    sym_q;
	logic          last_q;
	sym_kind_t     kind_q;
	op_code_t      code_q;

	op_code_t   top;
	logic       accept;
	logic [CW-1:0] count_m1;

	assign top      = op_code_t'(st_rdata);
	assign accept   = s_tvalid && s_tready;
	assign count_m1 = count_q - CW'(1);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_FLUSH;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			count_q <= count_d;
		end
	end

	// input beat capture
	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q  <= s_tdata;
			last_q <= s_tlast;
			kind_q <= sym_kind(s_tdata);
			code_q <= sym_code(s_tdata);
		end
	end

	// next state and outputs
	always_comb begin
		state_d    = state_q;
		mode_d     = mode_q;
		count_d    = count_q;
		s_tready   = 1'b0;
		st_we      = 1'b0;
		st_waddr   = count_q[AW-1:0];
		st_wdata   = code_q;
		st_re      = 1'b0;
		st_raddr   = count_m1[AW-1:0];
		req        = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (kind_q)
					KIND_LPAR: state_d = ST_PUSH;
					KIND_RPAR: begin
						mode_d  = MODE_CLOSE;
						state_d = (count_q == '0) ? ST_FAULT : ST_READ;
					end
					KIND_OPER: begin
						mode_d  = MODE_OPER;
						state_d = (count_q == '0) ? ST_PUSH : ST_READ;
					end
					default: begin
						// operand goes straight out
						req.emit = 1'b1;
						req.beat = '{sym: sym_q, has: 1'b1, fault: 1'b0};
						if (ok) begin
							state_d = ST_FINISH;
						end
					end
				endcase
			end
			ST_READ: begin
				st_re   = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				req.beat = '{sym: code_char(top), has: 1'b1, fault: 1'b0};
				case (mode_q)
					MODE_CLOSE: begin
						if (top == OP_LPAR) begin
							count_d = count_m1;
							state_d = ST_FINISH;
						end else begin
							req.emit = 1'b1;
							if (ok) begin
								count_d = count_m1;
								state_d = (count_q == CW'(1)) ? ST_FAULT : ST_READ;
							end
						end
					end
					MODE_OPER: begin
						if (code_prio(code_q) > code_prio(top)) begin
							state_d = ST_PUSH;
						end else begin
							req.emit = 1'b1;
							if (ok) begin
								count_d = count_m1;
								state_d = (count_q == CW'(1)) ? ST_PUSH : ST_READ;
							end
						end
					end
					default: begin
						// end-of-text flush
						req.emit = 1'b1;
						if (ok) begin
							count_d = count_m1;
							state_d = (count_q == CW'(1)) ? ST_FINISH : ST_READ;
						end
					end
				endcase
			end
			ST_PUSH: begin
				if (count_q == CW'(DEPTH)) begin
					req.emit = 1'b1;
					req.beat = '{sym: 8'h00, has: 1'b0, fault: 1'b1};
					if (ok) begin
						state_d = ST_FINISH;
					end
				end else begin
					st_we   = 1'b1;
					count_d = count_q + CW'(1);
					state_d = ST_FINISH;
				end
			end
			ST_FAULT: begin
				req.emit = 1'b1;
				req.beat = '{sym: 8'h00, has: 1'b0, fault: 1'b1};
				if (ok) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (last_q && count_q != '0) begin
					mode_d  = MODE_FLUSH;
					state_d = ST_READ;
				end else begin
					// release the held beat, marking it last at end of text
					req.drain      = 1'b1;
					req.drain_last = last_q;
					if (ok) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* rtl/infix_to_postfix_converter_top.sv */
`timescale 1ns / 1ps
// Flow: an accepted operand is registered in the holding stage; each stack entry examined
// is read, then compared and emitted into the holding stage. A held result moves to the
// output register with the next result or at the end of the character's sequence. A new
// character is accepted only once the previous character's sequence has finished.
// Output stalls lengthen a sequence.
// Reset: arst_n clears the stack count, sequencer state and output valid; no clearing pass.
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top: streaming shunting-yard converter
// Infix characters in, postfix characters out, with stack fault flags.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top #(
	parameter int STACK_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] symbol
	input  logic       s_tlast,   // end_of_text
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_symbol
	output logic [1:0] m_tuser,   // [0] has_symbol, [1] fault
	output logic       m_tlast    // last_out
);
	import i2p_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic          st_we;
	logic [AW-1:0] st_waddr;
	logic [2:0]    st_wdata;
	logic          st_re;
	logic [AW-1:0] st_raddr;
	logic [2:0]    st_rdata;
	emit_req_t     req;
	logic          ok;

	i2p_seq #(
		.DEPTH(STACK_DEPTH),
		.AW   (AW),
		.CW   (CW)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.st_we   (st_we),
		.st_waddr(st_waddr),
		.st_wdata(st_wdata),
		.st_re   (st_re),
		.st_raddr(st_raddr),
		.st_rdata(st_rdata),
		.req     (req),
		.ok      (ok)
	);

	i2p_stack #(
		.DEPTH(STACK_DEPTH),
		.AW   (AW)
	) u_stack (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.re   (st_re),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	i2p_outbuf u_outbuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.ok      (ok),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

/* tb/sv/i2p_postfix_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_postfix_checker: scoreboard of the infix-to-postfix converter
// Watches both stream channels, runs its own shunting-yard stack on every
// accepted infix beat and checks each postfix beat against the oldest one due.
// ----------------------------------------------------------------------------
module i2p_postfix_checker #(
	parameter int STACK_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] symbol
	input  logic       s_tlast,   // end_of_text
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [7:0] out_symbol
	input  logic [1:0] m_tuser,   // [0] has_symbol, [1] fault
	input  logic       m_tlast,   // last_out
	output int         mismatches,
	output int         pending,
	output int         beats_seen,
	output int         faults_seen,
	output int         texts_seen
);
	import i2p_pkg::*;

	localparam int IW = $clog2(STACK_DEPTH);

	typedef struct packed {
		logic [7:0] sym;
		logic       has_sym;
		logic       fault;
		logic       last_out;
	} postfix_beat_t;

	postfix_beat_t expected_postfix[$];

	// shadow operator stack
	op_code_t    op_stack [STACK_DEPTH];
	int unsigned op_depth;

	function automatic int unsigned rank(input op_code_t c);
		case (c)
			OP_MUL, OP_DIV: return 2;
			OP_ADD, OP_SUB: return 1;
			default:        return 0;
		endcase
	endfunction

	function automatic logic [7:0] glyph(input op_code_t c);
		case (c)
			OP_ADD:  return CH_ADD;
			OP_SUB:  return CH_SUB;
			OP_MUL:  return CH_MUL;
			OP_DIV:  return CH_DIV;
			default: return CH_LPAR;
		endcase
	endfunction

	function void queue_beat(input logic [7:0] s, input logic h, input logic f);
		postfix_beat_t b;
		b = '{sym: s, has_sym: h, fault: f, last_out: 1'b0};
		expected_postfix.insert(expected_postfix.size(), b);
	endfunction

	// full stack drops the push and yields a fault beat
	function void push_op(input op_code_t c);
		if (op_depth >= STACK_DEPTH) begin
			queue_beat(8'h00, 1'b0, 1'b1);
		end else begin
			op_stack[IW'(op_depth)] = c;
			op_depth++;
		end
	endfunction

	// one infix character in, its postfix beats appended
	function void convert_char(input logic [7:0] ch, input logic eot);
		op_code_t code;
		op_code_t top;
		logic     found;
		int       start;
		start = expected_postfix.size();
		case (ch)
			CH_LPAR: begin
				push_op(OP_LPAR);
			end
			CH_RPAR: begin
				found = 1'b0;
				while (op_depth > 0 && !found) begin
					op_depth--;
					top = op_stack[IW'(op_depth)];
					if (top == OP_LPAR)
						found = 1'b1;
					else
						queue_beat(glyph(top), 1'b1, 1'b0);
				end
				// underflow: no matching '('
				if (!found)
					queue_beat(8'h00, 1'b0, 1'b1);
			end
			CH_ADD, CH_SUB, CH_MUL, CH_DIV: begin
				case (ch)
					CH_ADD:  code = OP_ADD;
					CH_SUB:  code = OP_SUB;
					CH_MUL:  code = OP_MUL;
					default: code = OP_DIV;
				endcase
				while (op_depth > 0 && rank(op_stack[IW'(op_depth - 1)]) >= rank(code)) begin
					op_depth--;
					queue_beat(glyph(op_stack[IW'(op_depth)]), 1'b1, 1'b0);
				end
				push_op(code);
			end
			default: begin
				queue_beat(ch, 1'b1, 1'b0);
			end
		endcase
		// end of text: flush, bare marker if nothing came out
		if (eot) begin
			while (op_depth > 0) begin
				op_depth--;
				queue_beat(glyph(op_stack[IW'(op_depth)]), 1'b1, 1'b0);
			end
			if (expected_postfix.size() == start)
				queue_beat(8'h00, 1'b0, 1'b0);
			expected_postfix[expected_postfix.size() - 1].last_out = 1'b1;
		end
	endfunction

	// sample both channels at the rising edge
	always @(posedge clk) begin
		postfix_beat_t got;
		postfix_beat_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				convert_char(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				got = '{sym: m_tdata, has_sym: m_tuser[0], fault: m_tuser[1],
					last_out: m_tlast};
				beats_seen++;
				if (got.fault)
					faults_seen++;
				if (got.last_out)
					texts_seen++;
				if (expected_postfix.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected beat sym=%h has=%b fault=%b last=%b",
							$realtime, got.sym, got.has_sym, got.fault, got.last_out);
				end else begin
					want = expected_postfix.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch expected %h/%b/%b/%b got %h/%b/%b/%b",
								$realtime,
								want.sym, want.has_sym, want.fault, want.last_out,
								got.sym, got.has_sym, got.fault, got.last_out);
					end
				end
			end
			pending = expected_postfix.size();
		end
	end

endmodule

/* tb/sv/infix_to_postfix_converter_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top_tb: stimulus and verdict for the converter
// Feeds directed and random infix texts (well-formed, deeply nested, noise)
// with random gaps on both sides, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top_tb;
	import i2p_pkg::*;

	localparam int STACK_DEPTH = 16;
	localparam int TEXT_ITEMS  = 460;
	localparam int HOLD_AT     = 250;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 60;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [7:0] symbol
	logic       s_tlast;   // end_of_text
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;   // [7:0] out_symbol
	logic [1:0] m_tuser;   // [0] has_symbol, [1] fault
	logic       m_tlast;   // last_out

	int mismatches, pending, beats_seen, faults_seen, texts_seen;
	int tx_count;
	int texts_sent;
	int hold_left;
	int idle_cycles;
	bit tx_gaps;
	bit rx_gaps;
	bit hold_done;

	infix_to_postfix_converter_top #(.STACK_DEPTH(STACK_DEPTH)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	i2p_postfix_checker #(.STACK_DEPTH(STACK_DEPTH)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.mismatches  (mismatches),
		.pending     (pending),
		.beats_seen  (beats_seen),
		.faults_seen (faults_seen),
		.texts_seen  (texts_seen)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// output side: random stalls, one long hold-off once enough input has gone in
	always begin
		@(negedge clk);
		if (!hold_done && tx_count >= HOLD_AT) begin
			hold_done = 1'b1;
			m_tready <= 1'b0;
			hold_left = HOLD_CYCLES;
			while (hold_left > 0) begin
				@(negedge clk);
				hold_left--;
			end
		end
		m_tready <= !(rx_gaps && $urandom_range(0, 99) < 37);
	end

	// watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d results outstanding",
					STALL_LIMIT, pending);
				$display("status: fail");
				$finish;
			end
		end
	end

	function automatic logic [7:0] rand_operand();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_LPAR || c == CH_RPAR || c == CH_ADD || c == CH_SUB ||
			c == CH_MUL || c == CH_DIV);
		return c;
	endfunction

	// well-formed infix text with random nesting
	function automatic void make_infix(ref logic [7:0] text[$], input int max_depth,
		input int open_pct, input int operands);
		logic [7:0] ops [4];
		int         depth;
		int         placed;
		ops    = '{CH_ADD, CH_SUB, CH_MUL, CH_DIV};
		depth  = 0;
		placed = 0;
		text.delete();
		while (placed < operands) begin
			while (depth < max_depth && $urandom_range(0, 99) < open_pct) begin
				text.insert(text.size(), CH_LPAR);
				depth++;
			end
			text.insert(text.size(), rand_operand());
			placed++;
			while (depth > 0 && $urandom_range(0, 99) < 35) begin
				text.insert(text.size(), CH_RPAR);
				depth--;
			end
			if (placed < operands)
				text.insert(text.size(), ops[2'($urandom_range(0, 3))]);
		end
		repeat (depth) text.insert(text.size(), CH_RPAR);
	endfunction

	// one input beat; valid stays up until the next falling edge
	task automatic send_beat(input logic [7:0] ch, input logic eot);
		@(negedge clk);
		while (tx_gaps && $urandom_range(0, 99) < 37) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= eot;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tx_count++;
	endtask

	task automatic send_text(input logic [7:0] text[$]);
		foreach (text[i])
			send_beat(text[i], i == text.size() - 1);
		texts_sent++;
	endtask

	task automatic send_string(input string s);
		logic [7:0] text[$];
		for (int i = 0; i < s.len(); i++)
			text.insert(text.size(), s[i]);
		send_text(text);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		logic [7:0] text[$];
		logic [7:0] specials [6];
		int         pick;
		bit         pause_done;
		specials    = '{CH_LPAR, CH_RPAR, CH_ADD, CH_SUB, CH_MUL, CH_DIV};
		pause_done  = 1'b0;
		tx_count    = 0;
		texts_sent  = 0;
		tx_gaps     = 1'b1;
		rx_gaps     = 1'b1;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = 8'h00;
		s_tlast     = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// directed: precedence, parentheses, underflow, open '(' at end,
		// empty end marker, operand code extremes
		send_string("a+b*c");
		send_string("a*b-c");
		send_string("(a-b)/c");
		send_string(")");
		send_string("(");
		send_string("()");
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b1);
		texts_sent++;

		// random texts
		while (tx_count < TEXT_ITEMS) begin
			if (tx_count >= 120 && tx_count < 200) begin
				tx_gaps = 1'b0;
				rx_gaps = 1'b0;
			end else begin
				tx_gaps = 1'b1;
				rx_gaps = 1'b1;
			end
			if (!pause_done && tx_count >= 350) begin
				pause_done = 1'b1;
				wait_drained();
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				make_infix(text, 3, 25, $urandom_range(1, 6));
			end else if (pick < 80) begin
				// nests past the stack depth
				make_infix(text, 20, 70, $urandom_range(4, 12));
			end else begin
				text.delete();
				repeat ($urandom_range(1, 8)) begin
					if ($urandom_range(0, 1))
						text.insert(text.size(), specials[3'($urandom_range(0, 5))]);
					else
						text.insert(text.size(), 8'($urandom_range(0, 255)));
				end
			end
			send_text(text);
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("run: %0d characters in %0d texts, %0d postfix beats, %0d fault beats",
			tx_count, texts_sent, beats_seen, faults_seen);
		$display("run: %0d end markers seen, %0d mismatches", texts_seen, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
